// ----- hw/rtl/crast_pkg.sv -----
// crast_pkg: shared widths, command codes and the iteration record of the circle rasterizer
// no dependencies; imported by every module of the block except crast_fifo
package crast_pkg;

  localparam int unsigned RAD_BITS = 14;
  localparam int unsigned OFS_BITS = 16;
  localparam int unsigned ERR_BITS = 20;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // index of the final beat of one iteration in each mode
  localparam logic [1:0] LAST_PT_OUTLINE  = 2'd3;
  localparam logic [1:0] LAST_SPAN_FILLED = 2'd2;

  typedef struct packed {
    logic signed [OFS_BITS-1:0] ofs_x;
    logic signed [OFS_BITS-1:0] ofs_y;
    logic                       fill;
    logic                       last;
  } iter_t;

endpackage

// ----- hw/rtl/circle_rasterizer_core.sv -----
// circle_rasterizer_core: top level of the midpoint circle rasterizer
// depends on crast_pkg, crast_front, crast_fifo and crast_back
//
// A start beat loads center, radius and mode and produces nothing; each step beat runs one
// midpoint iteration and produces four point beats (outline) or three span beats (filled),
// the last one of the final iteration flagged by last_of_circle_o. Steps while idle are
// dropped. The front takes one command per cycle while the queue is not full and queues
// iterations in a two-entry queue; the result port moves one beat per cycle while out_stall_i
// is low, so sustained steps are bounded by the beats that each one produces, set by the single
// registered result port. Coordinates wrap at COORD_BITS.
module circle_rasterizer_core import crast_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  input  logic [RAD_BITS-1:0]   radius_i,
  input  logic                  filled_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] x_start_o,
  output logic [COORD_BITS-1:0] y_start_o,
  output logic [COORD_BITS-1:0] x_end_o,
  output logic [COORD_BITS-1:0] y_end_o,
  output logic                  last_of_circle_o
);

  localparam int unsigned RecBits = 2 * COORD_BITS + $bits(iter_t);

  logic                  push, full, pop, empty;
  logic [COORD_BITS-1:0] push_cx, push_cy, head_cx, head_cy;
  iter_t                 push_it, head_it;
  logic [RecBits-1:0]    head_data;

  crast_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .filled_i   (filled_i),
    .full_i     (full),
    .push_o     (push),
    .push_cx_o  (push_cx),
    .push_cy_o  (push_cy),
    .push_it_o  (push_it)
  );

  crast_fifo #(.WIDTH(RecBits)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_cx, push_cy, push_it}),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_data_o (head_data)
  );

  assign {head_cx, head_cy, head_it} = head_data;

  crast_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (!empty),
    .head_cx_i        (head_cx),
    .head_cy_i        (head_cy),
    .head_it_i        (head_it),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .x_start_o        (x_start_o),
    .y_start_o        (y_start_o),
    .x_end_o          (x_end_o),
    .y_end_o          (y_end_o),
    .last_of_circle_o (last_of_circle_o)
  );

endmodule

// ----- hw/rtl/crast_front.sv -----
// crast_front: command intake and midpoint error-term update, one iteration per cycle while the queue is not full
// depends on crast_pkg; feeds one iteration record per step into the queue
module crast_front import crast_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  input  logic [RAD_BITS-1:0]   radius_i,
  input  logic                  filled_i,
  input  logic                  full_i,
  output logic                  push_o,
  output logic [COORD_BITS-1:0] push_cx_o,
  output logic [COORD_BITS-1:0] push_cy_o,
  output iter_t                 push_it_o
);

  logic                       busy_q;
  logic                       fill_q;
  logic [COORD_BITS-1:0]      cx_q, cy_q;
  logic signed [OFS_BITS-1:0] ofs_x_q, ofs_y_q;
  logic signed [ERR_BITS-1:0] err_q;

  logic                       accept, start, push;
  logic signed [ERR_BITS-1:0] xe, ye, y1e, x1e, err1, err2;
  logic signed [OFS_BITS-1:0] x_nxt, y_nxt;
  logic                       step_y, step_x, last;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign start      = accept && (command_i == CMD_START);
  assign push       = accept && (command_i == CMD_STEP) && busy_q;

  // error-term update
  always_comb begin
    xe     = ERR_BITS'(ofs_x_q);
    ye     = ERR_BITS'(ofs_y_q);
    step_y = (err_q <= ye);
    y_nxt  = step_y ? ofs_y_q + OFS_BITS'(1) : ofs_y_q;
    y1e    = ERR_BITS'(y_nxt);
    err1   = step_y ? err_q + (y1e <<< 1) + ERR_BITS'(1) : err_q;
    step_x = (err_q > xe) || (err1 > y1e);
    x_nxt  = step_x ? ofs_x_q + OFS_BITS'(1) : ofs_x_q;
    x1e    = ERR_BITS'(x_nxt);
    err2   = step_x ? err1 + (x1e <<< 1) + ERR_BITS'(1) : err1;
    last   = !x_nxt[OFS_BITS-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start) begin
      busy_q <= 1'b1;
    end else if (push && last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      fill_q  <= filled_i;
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      ofs_x_q <= OFS_BITS'(0) - OFS_BITS'(radius_i);
      ofs_y_q <= '0;
      err_q   <= ERR_BITS'(2) - ERR_BITS'({radius_i, 1'b0});
    end else if (push) begin
      ofs_x_q <= x_nxt;
      ofs_y_q <= y_nxt;
      err_q   <= err2;
    end
  end

  assign push_o          = push;
  assign push_cx_o       = cx_q;
  assign push_cy_o       = cy_q;
  assign push_it_o.ofs_x = ofs_x_q;
  assign push_it_o.ofs_y = ofs_y_q;
  assign push_it_o.fill  = fill_q;
  assign push_it_o.last  = last;

  a_push_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> busy_q) else $error("iteration pushed while idle");

  a_last_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && last |=> !busy_q) else $error("busy still set after final iteration");

endmodule

// ----- hw/rtl/crast_fifo.sv -----
// crast_fifo: two-entry queue of iteration records between front and back
// no package dependency; width set by the instantiating module
module crast_fifo #(
  parameter int unsigned WIDTH = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o      = (count_q == 2'd2);
  assign empty_o     = (count_q == 2'd0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign head_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2) else $error("queue count out of range");

endmodule

// ----- hw/rtl/crast_back.sv -----
// crast_back: expands an iteration record into points or spans, one beat per cycle
// unless stalled; depends on crast_pkg; reads the queue head, drives the registered result port
module crast_back import crast_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  logic [COORD_BITS-1:0] head_cx_i,
  input  logic [COORD_BITS-1:0] head_cy_i,
  input  iter_t                 head_it_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] x_start_o,
  output logic [COORD_BITS-1:0] y_start_o,
  output logic [COORD_BITS-1:0] x_end_o,
  output logic [COORD_BITS-1:0] y_end_o,
  output logic                  last_of_circle_o
);

  logic                       out_valid_q;
  logic [1:0]                 k_q;
  logic [COORD_BITS-1:0]      xs_q, ys_q, xe_q, ye_q;
  logic                       lst_q;

  logic signed [OFS_BITS-1:0] hx, hy;
  logic [COORD_BITS-1:0]      xo, yo;
  logic [COORD_BITS-1:0]      cx_px, cx_mx, cx_py, cx_my, cy_py, cy_my, cy_px, cy_mx;
  logic [COORD_BITS-1:0]      xs_d, ys_d, xe_d, ye_d;
  logic [1:0]                 last_idx;
  logic                       load, end_of_rec;

  assign hx    = head_it_i.ofs_x;
  assign hy    = head_it_i.ofs_y;
  assign xo    = COORD_BITS'(hx);
  assign yo    = COORD_BITS'(hy);
  assign cx_px = head_cx_i + xo;
  assign cx_mx = head_cx_i - xo;
  assign cx_py = head_cx_i + yo;
  assign cx_my = head_cx_i - yo;
  assign cy_py = head_cy_i + yo;
  assign cy_my = head_cy_i - yo;
  assign cy_px = head_cy_i + xo;
  assign cy_mx = head_cy_i - xo;

  assign last_idx   = head_it_i.fill ? LAST_SPAN_FILLED : LAST_PT_OUTLINE;
  assign end_of_rec = (k_q == last_idx);
  assign load       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o      = load && end_of_rec;

  always_comb begin
    xs_d = head_cx_i;
    ys_d = head_cy_i;
    xe_d = head_cx_i;
    ye_d = head_cy_i;
    if (head_it_i.fill) begin
      unique case (k_q)
        2'd0: begin
          xs_d = cx_px; ys_d = cy_py; xe_d = cx_mx; ye_d = cy_py;
        end
        2'd1: begin
          xs_d = cx_px; ys_d = head_cy_i; xe_d = cx_px; ye_d = cy_my;
        end
        default: begin
          xs_d = cx_mx; ys_d = cy_my; xe_d = head_cx_i; ye_d = cy_my;
        end
      endcase
    end else begin
      unique case (k_q)
        2'd0: begin
          xs_d = cx_px; ys_d = cy_my; xe_d = cx_px; ye_d = cy_my;
        end
        2'd1: begin
          xs_d = cx_mx; ys_d = cy_py; xe_d = cx_mx; ye_d = cy_py;
        end
        2'd2: begin
          xs_d = cx_py; ys_d = cy_px; xe_d = cx_py; ye_d = cy_px;
        end
        default: begin
          xs_d = cx_my; ys_d = cy_mx; xe_d = cx_my; ye_d = cy_mx;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= 2'd0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      k_q         <= end_of_rec ? 2'd0 : k_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      xs_q  <= xs_d;
      ys_q  <= ys_d;
      xe_q  <= xe_d;
      ye_q  <= ye_d;
      lst_q <= head_it_i.last && end_of_rec;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign x_start_o        = xs_q;
  assign y_start_o        = ys_q;
  assign x_end_o          = xe_q;
  assign y_end_o          = ye_q;
  assign last_of_circle_o = lst_q;

  a_filled_three_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && head_it_i.fill |-> k_q != LAST_PT_OUTLINE)
    else $error("filled record expanded past its third span");

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for circle_rasterizer_core, random circles with per-beat gaps and stalls
// depends on crast_pkg and circle_rasterizer_core; a midpoint predictor holds the expected segments
`timescale 1ns / 1ps

module tb;
  import crast_pkg::*;

  localparam int unsigned COORD_BITS = 16;
  localparam int TOTAL_ITEMS = 330;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] ys;
    logic [COORD_BITS-1:0] xe;
    logic [COORD_BITS-1:0] ye;
    logic                  last;
  } seg_t;

  class circle_tracker;
    bit                    busy;
    bit                    fill;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    int                    ox;
    int                    oy;
    int                    err;
    seg_t                  expected_segs[$];
    int                    mismatches;

    function automatic logic [COORD_BITS-1:0] wrap(logic [COORD_BITS-1:0] base, int delta);
      return base + COORD_BITS'(delta);
    endfunction

    function automatic seg_t seg(logic [COORD_BITS-1:0] xs, logic [COORD_BITS-1:0] ys,
                                 logic [COORD_BITS-1:0] xe, logic [COORD_BITS-1:0] ye);
      seg_t s;
      s = '{xs, ys, xe, ye, 1'b0};
      return s;
    endfunction

    function automatic void note_command(cmd_e cmd, logic [COORD_BITS-1:0] cx_in,
                                         logic [COORD_BITS-1:0] cy_in,
                                         logic [RAD_BITS-1:0] r, logic f);
      seg_t segs[4];
      int   n;
      int   x;
      int   y;
      int   e;
      if (cmd == CMD_START) begin
        cx = cx_in;
        cy = cy_in;
        fill = f;
        ox = -int'(r);
        oy = 0;
        err = 2 - 2 * int'(r);
        busy = 1'b1;
        return;
      end
      if (!busy) return;
      x = ox;
      y = oy;
      if (fill) begin
        segs[0] = seg(wrap(cx, x), wrap(cy, y), wrap(cx, -x), wrap(cy, y));
        segs[1] = seg(wrap(cx, x), cy, wrap(cx, x), wrap(cy, -y));
        segs[2] = seg(wrap(cx, -x), wrap(cy, -y), cx, wrap(cy, -y));
        n = 3;
      end else begin
        segs[0] = seg(wrap(cx, x), wrap(cy, -y), wrap(cx, x), wrap(cy, -y));
        segs[1] = seg(wrap(cx, -x), wrap(cy, y), wrap(cx, -x), wrap(cy, y));
        segs[2] = seg(wrap(cx, y), wrap(cy, x), wrap(cx, y), wrap(cy, x));
        segs[3] = seg(wrap(cx, -y), wrap(cy, -x), wrap(cx, -y), wrap(cy, -x));
        n = 4;
      end
      e = err;
      if (e <= oy) begin
        oy++;
        err += 2 * oy + 1;
      end
      if (e > ox || err > oy) begin
        ox++;
        err += 2 * ox + 1;
      end
      if (ox >= 0) begin
        busy = 1'b0;
        segs[n-1].last = 1'b1;
      end
      for (int k = 0; k < n; k++) expected_segs.push_back(segs[k]);
    endfunction

    function automatic void check_segment(seg_t got);
      seg_t want;
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected segment %h,%h - %h,%h last %b",
                   got.xs, got.ys, got.xe, got.ye, got.last);
        return;
      end
      want = expected_segs.pop_front();
      if (got.xs !== want.xs || got.ys !== want.ys || got.xe !== want.xe ||
          got.ye !== want.ye || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("segment mismatch: expected %h,%h - %h,%h last %b, got %h,%h - %h,%h last %b",
                   want.xs, want.ys, want.xe, want.ye, want.last,
                   got.xs, got.ys, got.xe, got.ye, got.last);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  command_i = 1'b0;
  logic [COORD_BITS-1:0] center_x_i = '0;
  logic [COORD_BITS-1:0] center_y_i = '0;
  logic [RAD_BITS-1:0]   radius_i = '0;
  logic                  filled_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COORD_BITS-1:0] x_start_o;
  logic [COORD_BITS-1:0] y_start_o;
  logic [COORD_BITS-1:0] x_end_o;
  logic [COORD_BITS-1:0] y_end_o;
  logic                  last_of_circle_o;

  circle_tracker tracker;
  bit            tx_calm = 1'b0;
  int            effective_items = 0;

  circle_rasterizer_core #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .radius_i        (radius_i),
    .filled_i        (filled_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .x_start_o       (x_start_o),
    .y_start_o       (y_start_o),
    .x_end_o         (x_end_o),
    .y_end_o         (y_end_o),
    .last_of_circle_o(last_of_circle_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(input cmd_e cmd, input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy, input logic [RAD_BITS-1:0] r,
                           input logic f);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i <= r;
    filled_i <= f;
    do @(posedge clk_i); while (in_stall_o);
    if (cmd == CMD_START || tracker.busy) effective_items++;
    tracker.note_command(cmd, cx, cy, r, f);
  endtask

  task automatic send_step();
    send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom), RAD_BITS'($urandom),
              1'($urandom));
  endtask

  task automatic run_random_circle();
    logic [RAD_BITS-1:0] r;
    int                  pick;
    int                  cut;
    int                  steps;
    pick = $urandom_range(0, 19);
    if (pick == 0) r = RAD_BITS'($urandom_range(49, 16383));
    else if (pick <= 2) r = RAD_BITS'($urandom_range(16, 48));
    else r = RAD_BITS'($urandom_range(0, 15));
    tx_calm = ($urandom_range(0, 3) == 0);
    cut = (r > 48 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : -1;
    send_item(CMD_START, COORD_BITS'($urandom), COORD_BITS'($urandom), r, 1'($urandom));
    steps = 0;
    while (tracker.busy && steps != cut) begin
      send_step();
      steps++;
    end
    if ($urandom_range(0, 3) == 0) send_step();
  endtask

  initial begin
    seg_t got;
    int   wait_left;
    int   beats;
    bit   calm;
    wait_left = 0;
    beats = 0;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = '{x_start_o, y_start_o, x_end_o, y_end_o, last_of_circle_o};
        tracker.check_segment(got);
        beats++;
        if (beats % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        if (beats == 40 || beats == 500) wait_left = HOLD_CYCLES;
        else wait_left = calm ? 0 : $urandom_range(0, 7);
      end
      if (wait_left > 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst_ni);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    tracker = new;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle step, zero radius in both modes, wrap at the extremes
    send_step();
    send_item(CMD_START, 16'h0000, 16'h0000, 14'd0, 1'b0);
    send_step();
    send_step();
    send_item(CMD_START, 16'h7FFF, 16'h8000, 14'd0, 1'b1);
    send_step();
    send_item(CMD_START, 16'h8000, 16'h7FFF, 14'd1, 1'b0);
    while (tracker.busy) send_step();
    // largest radius, abandoned by a new start
    send_item(CMD_START, 16'h8000, 16'h8000, 14'h3FFF, 1'b1);
    send_step();
    send_step();
    send_item(CMD_START, 16'h7FFF, 16'h7FFF, 14'h3FFF, 1'b0);
    send_step();
    send_step();
    send_item(CMD_START, 16'hFFFF, 16'h0001, 14'd2, 1'b1);
    while (tracker.busy) send_step();

    while (effective_items < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        send_item(cmd_e'($urandom_range(0, 1)), COORD_BITS'($urandom), COORD_BITS'($urandom),
                  RAD_BITS'($urandom), 1'($urandom));
      else
        run_random_circle();
    end
    in_valid_i <= 1'b0;

    while (tracker.expected_segs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_segs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
